// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top RTL file of the complex FIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CFF_ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
`define CFF_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");
`else
`define CFF_ASSERT_RST(lbl, clk, rst_n, prop)
`define CFF_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

// ----- rtl/cff_pkg.sv -----
// Types and constants of the complex FIR filter.
package cff_pkg;

	localparam int TAPS_DEF = 64;
	localparam int IDX_W    = 6;
	localparam int DATA_W   = 16;
	localparam int MULT_W   = 2 * DATA_W;
	localparam int FRAC_W   = 15;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [IDX_W-1:0]         tap_index;
		logic signed [DATA_W-1:0] tap_re;
		logic signed [DATA_W-1:0] tap_im;
		logic signed [DATA_W-1:0] sample_re;
		logic signed [DATA_W-1:0] sample_im;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_re;
		logic signed [DATA_W-1:0] out_im;
		logic                     saturated;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} cplx_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [IDX_W-1:0] tap_index;
		cplx_t            tap;
	} cell_ctl_t;

endpackage

// ----- rtl/cff_cell.sv -----
// One filter cell: a delay slot, a tap, a complex multiplier and a partial-sum stage.
module cff_cell #(
	parameter int IDX   = 0,
	parameter int ACC_W = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cff_pkg::cell_ctl_t      ctl,
	input  cff_pkg::cplx_t          smp_in,
	output cff_pkg::cplx_t          smp_out,
	input  logic signed [ACC_W-1:0] sum_re_in,
	input  logic signed [ACC_W-1:0] sum_im_in,
	output logic signed [ACC_W-1:0] sum_re_out,
	output logic signed [ACC_W-1:0] sum_im_out
);

	localparam bit LOADABLE = IDX < (2 ** cff_pkg::IDX_W);

	cff_pkg::cplx_t smp_q;
	cff_pkg::cplx_t tap_q;
	logic signed [cff_pkg::MULT_W-1:0] m_rr, m_ii, m_ri, m_ir;
	logic signed [ACC_W-1:0] prod_re_q, prod_im_q;
	logic signed [ACC_W-1:0] sum_re_q, sum_im_q;
	logic hit;

	assign hit = LOADABLE && ctl.load && (ctl.tap_index == cff_pkg::IDX_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q <= '0;
			tap_q <= '0;
		end else begin
			if (ctl.shift) begin
				smp_q <= smp_in;
			end
			if (hit) begin
				tap_q <= ctl.tap;
			end
		end
	end

	assign m_rr = smp_q.re * tap_q.re;
	assign m_ii = smp_q.im * tap_q.im;
	assign m_ri = smp_q.re * tap_q.im;
	assign m_ir = smp_q.im * tap_q.re;

	always_ff @(posedge clk) begin
		prod_re_q <= ACC_W'(m_rr) - ACC_W'(m_ii);
		prod_im_q <= ACC_W'(m_ri) + ACC_W'(m_ir);
		sum_re_q  <= sum_re_in + prod_re_q;
		sum_im_q  <= sum_im_in + prod_im_q;
	end

	assign smp_out    = smp_q;
	assign sum_re_out = sum_re_q;
	assign sum_im_out = sum_im_q;

endmodule

// ----- rtl/cff_out.sv -----
// Output stage: floor shift by 15, saturation and the result register.
module cff_out #(
	parameter int ACC_W = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic signed [ACC_W-1:0] sum_re,
	input  logic signed [ACC_W-1:0] sum_im,
	output logic                    free,
	output logic                    result_valid,
	input  logic                    result_stall,
	output cff_pkg::result_t        result
);

	localparam int SH_W = ACC_W - cff_pkg::FRAC_W;
	localparam int TOP  = cff_pkg::DATA_W - 1;

	logic signed [SH_W-1:0] sh_re, sh_im;
	logic fit_re, fit_im;
	logic signed [cff_pkg::DATA_W-1:0] sat_re, sat_im;
	logic valid_q;
	cff_pkg::result_t result_q;

	// Dropping the low bits of a two's complement value rounds toward minus infinity.
	assign sh_re = sum_re[ACC_W-1:cff_pkg::FRAC_W];
	assign sh_im = sum_im[ACC_W-1:cff_pkg::FRAC_W];

	assign fit_re = (&sh_re[SH_W-1:TOP]) | ~(|sh_re[SH_W-1:TOP]);
	assign fit_im = (&sh_im[SH_W-1:TOP]) | ~(|sh_im[SH_W-1:TOP]);

	always_comb begin
		sat_re = sh_re[TOP:0];
		sat_im = sh_im[TOP:0];
		if (!fit_re) begin
			sat_re = sh_re[SH_W-1] ? {1'b1, {TOP{1'b0}}} : {1'b0, {TOP{1'b1}}};
		end
		if (!fit_im) begin
			sat_im = sh_im[SH_W-1] ? {1'b1, {TOP{1'b0}}} : {1'b0, {TOP{1'b1}}};
		end
	end

	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.out_re    <= sat_re;
			result_q.out_im    <= sat_im;
			result_q.saturated <= !fit_re || !fit_im;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/complex_fir_filter_unit.sv -----
// Complex FIR filter, direct form, built as a row of TAPS cells. A load transaction
// (action 0) writes one Q1.15 complex tap; indexes at or above TAPS are ignored. A
// sample transaction (action 1) shifts the sample into the delay line held in the
// cells, after which the complex products are summed at full width by a partial sum
// that moves one cell per cycle down the row. A counter armed by the sample tracks
// that ripple through the cell row, and the result is taken into the output register
// when it reaches zero and that register is free; item_stall stays high from the
// sample until then, so no load or sample is taken while one is being summed. The
// result is floor-shifted by 15 and saturated per component, with the saturated flag
// set on any clip, and waits in an output register so loads and the next sample can
// be taken meanwhile. Taps and delay line clear to zero at reset without a clearing pass.
`include "assert_macros.svh"

module complex_fir_filter_unit #(
	parameter int TAPS = cff_pkg::TAPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cff_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output cff_pkg::result_t  result
);

	localparam int ACC_W = cff_pkg::MULT_W + 1 + $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS + 2);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic accept, take, free;
	cff_pkg::cell_ctl_t ctl;
	cff_pkg::cplx_t smp_in;
	cff_pkg::cplx_t smp [TAPS];
	logic signed [ACC_W-1:0] psum_re [TAPS];
	logic signed [ACC_W-1:0] psum_im [TAPS];

	assign item_stall = busy_q;
	assign accept     = item_valid && !item_stall;
	assign take       = busy_q && (cnt_q == '0) && free;

	assign ctl.shift     = accept && (item.action == cff_pkg::ACT_SAMPLE);
	assign ctl.load      = accept && (item.action == cff_pkg::ACT_LOAD);
	assign ctl.tap_index = item.tap_index;
	assign ctl.tap.re    = item.tap_re;
	assign ctl.tap.im    = item.tap_im;

	assign smp_in.re = item.sample_re;
	assign smp_in.im = item.sample_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.shift) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(TAPS + 1);
		end else if (take) begin
			busy_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		if (i == 0) begin : g_head
			cff_cell #(.IDX(i), .ACC_W(ACC_W)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.smp_in    (smp_in),
				.smp_out   (smp[i]),
				.sum_re_in ('0),
				.sum_im_in ('0),
				.sum_re_out(psum_re[i]),
				.sum_im_out(psum_im[i])
			);
		end else begin : g_body
			cff_cell #(.IDX(i), .ACC_W(ACC_W)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.smp_in    (smp[i-1]),
				.smp_out   (smp[i]),
				.sum_re_in (psum_re[i-1]),
				.sum_im_in (psum_im[i-1]),
				.sum_re_out(psum_re[i]),
				.sum_im_out(psum_im[i])
			);
		end
	end

	cff_out #(.ACC_W(ACC_W)) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sum_re      (psum_re[TAPS-1]),
		.sum_im      (psum_im[TAPS-1]),
		.free        (free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	`CFF_ASSERT_RST(a_sample_arms, clk, arst_n, ctl.shift |=> busy_q && (cnt_q == CNT_W'(TAPS + 1)))
	`CFF_ASSERT_RST(a_load_idle, clk, arst_n, ctl.load |=> !busy_q)
	`CFF_ASSERT_RST(a_result_timed, clk, arst_n, $rose(result_valid) |-> $past(busy_q) && ($past(cnt_q) == '0))
	`CFF_ASSERT_RST(a_take_frees, clk, arst_n, take |=> !busy_q && result_valid)

endmodule
